FILE: rtl/mms_pkg.sv
// Shared types and constants for the min/max stack.
`timescale 1ns / 1ps

package mms_pkg;

   localparam int WordW = 32;
   localparam int CountFieldW = 8;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic signed [WordW-1:0] WORD_MOST_NEG = 32'sh8000_0000;
   localparam logic signed [WordW-1:0] WORD_MOST_POS = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [WordW-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WordW-1:0] top_value;
      logic signed [WordW-1:0] min_value;
      logic signed [WordW-1:0] max_value;
      logic [CountFieldW-1:0]  count;
      logic                    is_empty;
      logic [1:0]              status;
   } rsp_type;

   // One stored entry: the word plus min/max of itself and all below it.
   typedef struct packed {
      logic signed [WordW-1:0] value;
      logic signed [WordW-1:0] min_value;
      logic signed [WordW-1:0] max_value;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic fill;
   } cmd_type;

   typedef struct packed {
      logic needs_fill;
   } sts_type;

endpackage

FILE: rtl/min_max_stack.sv
// Channel    Ports                 Handshake
// input      req_data (req_type)   taken when start && !busy
// result     rsp_data (rsp_type)   valid for the one cycle rsp_strobe is high
//
// Push and query: after the accept the block steps through EXEC, then REPLY, which raises
// the result strobe. Pop leaving a non-empty stack adds FILL between them, loading the
// new top entry from the registered memory read; busy stays high until REPLY ends.
// reset is synchronous; it empties the stack, storage contents are kept.
// The receiver cannot stall; every accepted item gives exactly one strobe.
`timescale 1ns / 1ps

module min_max_stack #(
   parameter int DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mms_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mms_pkg::rsp_type rsp_data
);
   import mms_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mms_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/mms_ctrl.sv
// Sequencer for the min/max stack: accept, execute, refill top, reply.
`timescale 1ns / 1ps

module mms_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mms_pkg::sts_type sts,
   output mms_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_strobe
);
   import mms_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.needs_fill ? ST_FILL : ST_REPLY;
         end
         ST_FILL:  state_in = ST_REPLY;
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC:  cmd.exec = 1'b1;
         ST_FILL:  cmd.fill = 1'b1;
         ST_REPLY: rsp_strobe = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

endmodule

FILE: rtl/mms_datapath.sv
// Stack storage, cached top entry, element count and result formatting.
`timescale 1ns / 1ps

module mms_datapath #(
   parameter int DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  mms_pkg::cmd_type cmd,
   input  mms_pkg::req_type req_data,
   output mms_pkg::sts_type sts,
   output mms_pkg::rsp_type rsp_data
);
   import mms_pkg::*;

   localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   logic [1:0]              op_ff;
   logic signed [WordW-1:0] value_ff;
   logic [CountW-1:0]       count_ff;
   logic [CountW-1:0]       count_in;
   logic [1:0]              status_ff;
   logic [1:0]              status_in;
   entry_type               top_ff;
   entry_type               top_in;

   logic              is_full;
   logic              is_zero;
   logic              do_push;
   logic              do_pop;
   logic [CountW-1:0] count_m2;
   logic [AddrW-1:0]  wr_addr;
   logic [AddrW-1:0]  rd_addr;
   entry_type         push_entry;

   assign is_full  = (count_ff == CountW'(DEPTH));
   assign is_zero  = (count_ff == '0);
   assign do_push  = cmd.exec && (op_ff == OP_PUSH) && !is_full;
   assign do_pop   = cmd.exec && (op_ff == OP_POP) && !is_zero;
   assign count_m2 = count_ff - CountW'(2);
   assign wr_addr  = count_ff[AddrW-1:0];
   assign rd_addr  = count_m2[AddrW-1:0];

   // After a pop the new top lives in memory unless the stack drains.
   assign sts.needs_fill = (op_ff == OP_POP) && (count_ff > CountW'(1));

   always_comb begin
      push_entry.value     = value_ff;
      push_entry.min_value = value_ff;
      push_entry.max_value = value_ff;
      if (!is_zero) begin
         if (top_ff.min_value < value_ff) push_entry.min_value = top_ff.min_value;
         if (top_ff.max_value > value_ff) push_entry.max_value = top_ff.max_value;
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      top_in    = top_ff;
      if (cmd.exec) begin
         status_in = STATUS_OK;
         unique case (op_ff)
            OP_PUSH: begin
               if (is_full) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  top_in   = push_entry;
                  count_in = count_ff + CountW'(1);
               end
            end
            OP_POP: begin
               if (is_zero) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  count_in = count_ff - CountW'(1);
               end
            end
            default: status_in = STATUS_OK;
         endcase
      end else if (cmd.fill) begin
         top_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.op;
         value_ff <= req_data.value;
      end
      status_ff <= status_in;
      top_ff    <= top_in;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_addr] <= push_entry;
      if (do_pop)  rd_data_ff   <= mem[rd_addr];
   end

   always_comb begin
      rsp_data.count  = CountFieldW'(count_ff);
      rsp_data.status = status_ff;
      if (is_zero) begin
         rsp_data.top_value = WORD_MOST_NEG;
         rsp_data.min_value = WORD_MOST_NEG;
         rsp_data.max_value = WORD_MOST_POS;
         rsp_data.is_empty  = 1'b1;
      end else begin
         rsp_data.top_value = top_ff.value;
         rsp_data.min_value = top_ff.min_value;
         rsp_data.max_value = top_ff.max_value;
         rsp_data.is_empty  = 1'b0;
      end
   end

endmodule

FILE: rtl/mms_checker.sv
// Port-level checks for the min/max stack, bound to the top level.
`timescale 1ns / 1ps

module mms_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mms_pkg::req_type req_data,
   input logic             rsp_strobe,
   input mms_pkg::rsp_type rsp_data
);
   import mms_pkg::*;

   logic unused_req;
   assign unused_req = ^req_data;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result without an item in flight");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_empty) |->
         (rsp_data.top_value == WORD_MOST_NEG && rsp_data.min_value == WORD_MOST_NEG &&
          rsp_data.max_value == WORD_MOST_POS && rsp_data.status != STATUS_OVERFLOW))
      else $error("empty stack reports wrong values");

endmodule

bind min_max_stack mms_checker u_mms_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
